// ===== rtl/core/htps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htps_pkg
// Shared types, codes, constants and the CRC-8 helper of the poll sequencer.
// ----------------------------------------------------------------------------
package htps_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned VALUE_W = 15;

    // Sensor command bytes.
    localparam logic [BYTE_W-1:0] CMD_TEMPERATURE = 8'hF3;
    localparam logic [BYTE_W-1:0] CMD_HUMIDITY    = 8'hF5;
    localparam logic [BYTE_W-1:0] CMD_NONE        = 8'h00;

    // CRC-8, x^8 + x^5 + x^4 + 1, initial value zero.
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // Fixed-point conversion: value = ((raw * SCALE) >> 16) - OFFSET.
    localparam logic [14:0]        TEMP_SCALE   = 15'd17572;
    localparam logic [13:0]        HUM_SCALE    = 14'd12500;
    localparam logic [RAW_W-1:0]   HUM_RAW_FLIP = 16'h0002;
    localparam logic signed [15:0] TEMP_OFFSET  = 16'sd4685;
    localparam logic signed [15:0] HUM_OFFSET   = 16'sd600;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_POLLING = 2'd1,
        STATUS_TIMEOUT = 2'd2,
        STATUS_BAD_CRC = 2'd3
    } status_t;

    typedef enum logic {
        BUS_WRITE = 1'b0,
        BUS_READ  = 1'b1
    } bus_kind_t;

    // Outcome of checking and converting one three-byte read.
    typedef struct packed {
        logic                      crc_ok;
        logic signed [VALUE_W-1:0] temperature;
        logic signed [VALUE_W-1:0] humidity;
    } conv_t;

    // Shifts one byte through the CRC register, most significant bit first.
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (crc[BYTE_W-1])
            begin
                crc = (crc << 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc << 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/htps_tick_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htps_tick_if
// Poll tick channel: the outcome of the bus transaction that was requested.
// ----------------------------------------------------------------------------
interface htps_tick_if
    import htps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              bus_ok;
    logic [BYTE_W-1:0] byte_high;
    logic [BYTE_W-1:0] byte_low;
    logic [BYTE_W-1:0] byte_check;

    modport source (output valid, bus_ok, byte_high, byte_low, byte_check, input ready);
    modport sink   (input valid, bus_ok, byte_high, byte_low, byte_check, output ready);
endinterface

// ===== rtl/core/htps_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htps_result_if
// Result channel: bus request for the next tick, status and stored values.
// ----------------------------------------------------------------------------
interface htps_result_if
    import htps_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      bus_kind;
    logic [BYTE_W-1:0]         command_byte;
    logic [1:0]                status_code;
    logic signed [VALUE_W-1:0] temperature_centi;
    logic signed [VALUE_W-1:0] humidity_centi;

    modport source (output valid, bus_kind, command_byte, status_code,
                    temperature_centi, humidity_centi, input ready);
    modport sink   (input valid, bus_kind, command_byte, status_code,
                    temperature_centi, humidity_centi, output ready);
endinterface

// ===== rtl/core/htps_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htps_calc
// CRC check of a raw reading and its conversion to hundredths.
// ----------------------------------------------------------------------------
module htps_calc
    import htps_pkg::*;
(
    input  logic [BYTE_W-1:0] byte_high,
    input  logic [BYTE_W-1:0] byte_low,
    input  logic [BYTE_W-1:0] byte_check,
    output conv_t             conv
);
    logic [RAW_W-1:0]  raw;
    logic [RAW_W-1:0]  raw_hum;
    logic [BYTE_W-1:0] crc;
    logic [30:0]       temp_prod;
    logic [29:0]       hum_prod;
    logic signed [15:0] temp_wide;
    logic signed [15:0] hum_wide;

    assign raw     = {byte_high, byte_low};
    assign raw_hum = raw ^ HUM_RAW_FLIP;
    assign crc     = crc8_update(crc8_update(CMD_NONE, byte_high), byte_low);

    assign temp_prod = 31'(raw) * 31'(TEMP_SCALE);
    assign hum_prod  = 30'(raw_hum) * 30'(HUM_SCALE);

    // The products are never negative, so the shift is a plain floor.
    assign temp_wide = $signed({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;
    assign hum_wide  = $signed({2'b00, hum_prod[29:16]}) - HUM_OFFSET;

    assign conv.crc_ok      = (crc == byte_check);
    assign conv.temperature = temp_wide[VALUE_W-1:0];
    assign conv.humidity    = hum_wide[VALUE_W-1:0];
endmodule

// ===== rtl/core/humidity_temp_poll_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_poll_sequencer
// Alternates temperature and humidity polls of a sensor, checks each reading
// and keeps the last good values in hundredths.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Carries
//  -------   ---------  -------------  ------------------------------------------
//  tick      sink       valid / ready  bus_ok, byte_high, byte_low, byte_check
//  result    source     valid / ready  bus_kind, command_byte, status_code,
//                                      temperature_centi, humidity_centi
//
// One tick is taken every clock cycle while the result is not stalled; each
// tick gives exactly one result, through the tick register and then the
// result register. The throughput is set by the single CRC and conversion
// unit, which is combinational, so the state is ready again for the next tick.
// Reset clears the phase, the measurement kind, both stored values and both
// valid flags at once; there is no clearing pass.
// When the result is stalled the tick register fills, and then tick.ready
// falls until the waiting result transaction completes.
// ----------------------------------------------------------------------------
module humidity_temp_poll_sequencer
    import htps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    htps_tick_if.sink     tick,
    htps_result_if.source result
);
    // Tick register.
    logic              stage_valid_reg;
    logic              stage_bus_ok_reg;
    logic [BYTE_W-1:0] stage_high_reg;
    logic [BYTE_W-1:0] stage_low_reg;
    logic [BYTE_W-1:0] stage_check_reg;

    // Result register; the values are read straight from the stored state,
    // which only moves when a new result is loaded.
    logic              out_valid_reg;
    bus_kind_t         out_kind_reg;
    bus_kind_t         out_kind_next;
    logic [BYTE_W-1:0] out_cmd_reg;
    logic [BYTE_W-1:0] out_cmd_next;
    status_t           out_status_reg;
    status_t           out_status_next;

    // Sequencer state.
    logic                      read_phase_reg;
    logic                      read_phase_next;
    logic                      humidity_turn_reg;
    logic                      humidity_turn_next;
    logic signed [VALUE_W-1:0] temperature_reg;
    logic signed [VALUE_W-1:0] temperature_next;
    logic signed [VALUE_W-1:0] humidity_reg;
    logic signed [VALUE_W-1:0] humidity_next;
    logic                      temp_seen_reg;
    logic                      temp_seen_next;
    logic                      hum_seen_reg;
    logic                      hum_seen_next;

    logic  advance;
    logic  tick_take;
    conv_t conv;

    // The held tick moves on whenever the result register is free or being
    // emptied in this cycle.
    assign advance   = stage_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !stage_valid_reg || advance;
    assign tick_take = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            stage_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            stage_bus_ok_reg <= tick.bus_ok;
            stage_high_reg   <= tick.byte_high;
            stage_low_reg    <= tick.byte_low;
            stage_check_reg  <= tick.byte_check;
        end
    end

    htps_calc u_calc (
        .byte_high  (stage_high_reg),
        .byte_low   (stage_low_reg),
        .byte_check (stage_check_reg),
        .conv       (conv)
    );

    // Next state and result of the held tick.
    always_comb
    begin
        read_phase_next    = read_phase_reg;
        humidity_turn_next = humidity_turn_reg;
        temperature_next   = temperature_reg;
        humidity_next      = humidity_reg;
        temp_seen_next     = temp_seen_reg;
        hum_seen_next      = hum_seen_reg;
        out_kind_next      = BUS_WRITE;
        out_cmd_next       = CMD_NONE;
        out_status_next    = STATUS_TIMEOUT;

        if (!read_phase_reg)
        begin
            // Request phase: a timeout repeats the same command next tick.
            out_kind_next = BUS_WRITE;
            out_cmd_next  = humidity_turn_reg ? CMD_HUMIDITY : CMD_TEMPERATURE;
            if (stage_bus_ok_reg)
            begin
                read_phase_next = 1'b1;
                out_status_next = (temp_seen_reg && hum_seen_reg) ? STATUS_OK
                                                                  : STATUS_POLLING;
            end
        end
        else
        begin
            // Read phase: always returns to request, whatever the outcome.
            out_kind_next   = BUS_READ;
            read_phase_next = 1'b0;
            if (!stage_bus_ok_reg)
            begin
                out_status_next = STATUS_TIMEOUT;
            end
            else if (!conv.crc_ok)
            begin
                out_status_next = STATUS_BAD_CRC;
            end
            else
            begin
                if (!humidity_turn_reg)
                begin
                    temperature_next = conv.temperature;
                    temp_seen_next   = 1'b1;
                end
                else
                begin
                    humidity_next = conv.humidity;
                    hum_seen_next = 1'b1;
                end
                humidity_turn_next = !humidity_turn_reg;
                out_status_next    = (temp_seen_next && hum_seen_next) ? STATUS_OK
                                                                       : STATUS_POLLING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_phase_reg    <= 1'b0;
            humidity_turn_reg <= 1'b0;
            temperature_reg   <= '0;
            humidity_reg      <= '0;
            temp_seen_reg     <= 1'b0;
            hum_seen_reg      <= 1'b0;
        end
        else if (advance)
        begin
            read_phase_reg    <= read_phase_next;
            humidity_turn_reg <= humidity_turn_next;
            temperature_reg   <= temperature_next;
            humidity_reg      <= humidity_next;
            temp_seen_reg     <= temp_seen_next;
            hum_seen_reg      <= hum_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg   <= out_kind_next;
            out_cmd_reg    <= out_cmd_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.bus_kind          = out_kind_reg;
    assign result.command_byte      = out_cmd_reg;
    assign result.status_code       = out_status_reg;
    assign result.temperature_centi = temperature_reg;
    assign result.humidity_centi    = humidity_reg;

    // A read tick never carries a command byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == BUS_READ) |-> (out_cmd_reg == CMD_NONE))
    else $error("read result carries a command byte");

    // An ok status is only given once both values have been seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == STATUS_OK) |-> (temp_seen_reg && hum_seen_reg))
    else $error("ok status before both values are valid");

    // A read tick always hands the sequencer back to the request phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && read_phase_reg) |=> !read_phase_reg)
    else $error("read phase did not return to request");

    // Once a value has been seen it stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(temp_seen_reg) && !$fell(hum_seen_reg))
    else $error("a value valid flag was lost");

endmodule
